@@ hdl/hssc_pkg.sv @@
// Shared types, widths and the hall sector table of the six-step commutator.
package hssc_pkg;

  localparam int HallW  = 3;
  localparam int WordW  = 16;
  localparam int GateW  = 6;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  localparam logic [WordW-1:0] PeriodReset = 16'hFFFF;
  localparam logic [HallW-1:0] HallNone    = 3'd0;
  localparam logic [HallW-1:0] HallAll     = 3'd7;

  typedef enum logic [1:0] {
    PH_U = 2'd0,
    PH_V = 2'd1,
    PH_W = 2'd2
  } phase_t;

  typedef enum logic [0:0] {
    REG_PWM_PERIOD = 1'b0
  } reg_index_t;

  typedef struct packed {
    phase_t high_phase;
    phase_t low_phase;
  } sector_t;

  typedef struct packed {
    logic [WordW-1:0] compare_u;
    logic [WordW-1:0] compare_v;
    logic [WordW-1:0] compare_w;
    logic [GateW-1:0] gate_enables;
    logic             sector_changed;
    logic             outputs_off;
  } result_t;

  function automatic sector_t hall_sector(input logic [HallW-1:0] hall);
    sector_t s;
    case (hall)
      3'd1:    s = '{high_phase: PH_U, low_phase: PH_V};
      3'd2:    s = '{high_phase: PH_W, low_phase: PH_U};
      3'd3:    s = '{high_phase: PH_W, low_phase: PH_V};
      3'd4:    s = '{high_phase: PH_V, low_phase: PH_W};
      3'd5:    s = '{high_phase: PH_U, low_phase: PH_W};
      3'd6:    s = '{high_phase: PH_V, low_phase: PH_U};
      default: s = '{high_phase: PH_U, low_phase: PH_U};
    endcase
    return s;
  endfunction

endpackage

@@ hdl/hssc_if.sv @@
// Valid/ready channel interfaces for the commutator input and result streams.
interface hssc_in_if import hssc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HallW-1:0] hall_code;
  logic [WordW-1:0] duty_request;

  modport source (output valid, hall_code, duty_request, input ready);
  modport sink (input valid, hall_code, duty_request, output ready);
endinterface

interface hssc_out_if import hssc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] compare_u;
  logic [WordW-1:0] compare_v;
  logic [WordW-1:0] compare_w;
  logic [GateW-1:0] gate_enables;
  logic             sector_changed;
  logic             outputs_off;

  modport source (output valid, compare_u, compare_v, compare_w, gate_enables,
                  sector_changed, outputs_off, input ready);
  modport sink (input valid, compare_u, compare_v, compare_w, gate_enables,
                sector_changed, outputs_off, output ready);
endinterface

@@ hdl/hssc_commutate.sv @@
// Sector decode, duty clamp and compare/gate selection for one hall sample.
module hssc_commutate import hssc_pkg::*; (
  input  logic [HallW-1:0] hall_code,
  input  logic [WordW-1:0] duty_request,
  input  logic [WordW-1:0] pwm_period,
  input  logic [HallW-1:0] prev_hall,
  output result_t          res,
  output logic [HallW-1:0] prev_hall_nxt
);

  sector_t          sec;
  logic             off;
  logic [WordW-1:0] duty_clamped;
  logic [WordW-1:0] cmp [3];
  logic [GateW-1:0] gates;

  assign sec = hall_sector(hall_code);
  assign off = (duty_request == '0) || (hall_code == HallNone) || (hall_code == HallAll);
  assign duty_clamped = (duty_request > pwm_period) ? pwm_period : duty_request;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      if (phase_t'(p) == sec.high_phase) begin
        cmp[p] = duty_clamped;
      end else if (phase_t'(p) == sec.low_phase) begin
        cmp[p] = pwm_period;
      end else begin
        cmp[p] = '0;
      end
    end
    gates = '0;
    gates[{sec.high_phase, 1'b0}] = 1'b1;
    gates[{sec.low_phase, 1'b1}]  = 1'b1;
  end

  always_comb begin
    if (off) begin
      res           = '0;
      res.outputs_off = 1'b1;
      prev_hall_nxt = HallNone;
    end else begin
      res.compare_u      = cmp[0];
      res.compare_v      = cmp[1];
      res.compare_w      = cmp[2];
      res.gate_enables   = gates;
      res.sector_changed = (hall_code != prev_hall);
      res.outputs_off    = 1'b0;
      prev_hall_nxt      = hall_code;
    end
  end

endmodule

@@ hdl/hall_six_step_commutator_core.sv @@
// Six-step hall commutator: hall code and duty in, phase compares and gate enables out.
//
// in_ch carries one transaction per PWM update: a 3-bit hall code and a 16-bit
// duty. out_ch returns exactly one result transaction for each: the compare
// values of phases U, V and W, six gate enables, a sector-change flag and an
// all-off flag. Invalid hall codes (0, 7) or a zero duty switch every phase off.
// The APB port holds pwm_period at byte address 0; the duty is clamped to it and
// the sinking phase compares against it.
// A transaction passes through the input register, then through the decode into the
// result register. Throughput is one transaction per cycle while out_ch is ready,
// set by the two-register pipeline.
// When out_ch stalls, the result register holds and the input register fills;
// in_ch.ready drops only when both are occupied.
// Reset clears both pipeline valids and the stored hall code and loads
// pwm_period with 65535.
module hall_six_step_commutator_core import hssc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  hssc_in_if.sink          in_ch,
  hssc_out_if.source       out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic             s1_valid_r;
  logic [HallW-1:0] s1_hall_r;
  logic [WordW-1:0] s1_duty_r;
  logic             out_valid_r;
  result_t          out_res_r;
  result_t          res_nxt;
  logic [HallW-1:0] prev_hall_r;
  logic [HallW-1:0] prev_hall_nxt;
  logic [WordW-1:0] period_r;
  logic             advance;
  logic             in_take;
  logic             reg_sel;

  assign reg_sel = (paddr[AddrW-1] == REG_PWM_PERIOD);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DataW-WordW){1'b0}}, period_r} : '0;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  hssc_commutate u_commutate (
    .hall_code     (s1_hall_r),
    .duty_request  (s1_duty_r),
    .pwm_period    (period_r),
    .prev_hall     (prev_hall_r),
    .res           (res_nxt),
    .prev_hall_nxt (prev_hall_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PeriodReset;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_hall_r <= HallNone;
    end else begin
      if (psel && penable && pwrite && pready && reg_sel) begin
        period_r <= pwdata[WordW-1:0];
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          prev_hall_r <= prev_hall_nxt;
        end
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_hall_r <= in_ch.hall_code;
      s1_duty_r <= in_ch.duty_request;
    end
    if (advance && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.compare_u      = out_res_r.compare_u;
  assign out_ch.compare_v      = out_res_r.compare_v;
  assign out_ch.compare_w      = out_res_r.compare_w;
  assign out_ch.gate_enables   = out_res_r.gate_enables;
  assign out_ch.sector_changed = out_res_r.sector_changed;
  assign out_ch.outputs_off    = out_res_r.outputs_off;

  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.outputs_off) |->
      (out_res_r.gate_enables == '0 && !out_res_r.sector_changed &&
       out_res_r.compare_u == '0 && out_res_r.compare_v == '0 &&
       out_res_r.compare_w == '0))
    else $error("all-off result carries drive");

  a_two_gates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.outputs_off) |-> ($countones(out_res_r.gate_enables) == 2))
    else $error("active sector must enable one high and one low switch");

  a_hall_track: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r) |=> (prev_hall_r == $past(s1_hall_r) ||
                                 prev_hall_r == HallNone))
    else $error("stored hall code does not follow the applied sample");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted with both pipeline registers full");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the six-step hall commutator: directed and random hall/duty traffic.
module testbench;
  import hssc_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 218;
  localparam int ReportLimit   = 10;
  localparam logic [HallW-1:0] HallOrder [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

  class commutation_scoreboard;
    logic [WordW-1:0] period;
    logic [HallW-1:0] last_hall;
    result_t          expected_q[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      off_seen;
    int unsigned      changed_seen;
    int unsigned      clamped_seen;

    function new();
      period       = PeriodReset;
      last_hall    = HallNone;
      errors       = 0;
      checked      = 0;
      off_seen     = 0;
      changed_seen = 0;
      clamped_seen = 0;
    endfunction

    function void set_period(input logic [WordW-1:0] value);
      period = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(input logic [HallW-1:0] hall, input logic [WordW-1:0] duty);
      result_t          r;
      phase_t           hi;
      phase_t           lo;
      logic [WordW-1:0] level;
      logic [WordW-1:0] cmp [3];
      r = '0;
      if (duty == '0 || hall == HallNone || hall == HallAll) begin
        r.outputs_off = 1'b1;
        last_hall = HallNone;
        off_seen++;
      end else begin
        case (hall)
          3'd1: begin hi = PH_U; lo = PH_V; end
          3'd2: begin hi = PH_W; lo = PH_U; end
          3'd3: begin hi = PH_W; lo = PH_V; end
          3'd4: begin hi = PH_V; lo = PH_W; end
          3'd5: begin hi = PH_U; lo = PH_W; end
          default: begin hi = PH_V; lo = PH_U; end
        endcase
        level = duty;
        if (duty > period) begin
          level = period;
          clamped_seen++;
        end
        cmp[0] = '0;
        cmp[1] = '0;
        cmp[2] = '0;
        cmp[int'(hi)] = level;
        cmp[int'(lo)] = period;
        r.compare_u = cmp[0];
        r.compare_v = cmp[1];
        r.compare_w = cmp[2];
        r.gate_enables = (GateW'(1) << (2 * int'(hi))) | (GateW'(1) << (2 * int'(lo) + 1));
        if (hall != last_hall) begin
          r.sector_changed = 1'b1;
          last_hall = hall;
          changed_seen++;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(input result_t got);
      result_t exp;
      bit      bad;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("unexpected result: u=%h v=%h w=%h g=%b chg=%b off=%b",
                   got.compare_u, got.compare_v, got.compare_w, got.gate_enables,
                   got.sector_changed, got.outputs_off);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      bad = (got.compare_u !== exp.compare_u) || (got.compare_v !== exp.compare_v) ||
            (got.compare_w !== exp.compare_w) || (got.gate_enables !== exp.gate_enables) ||
            (got.sector_changed !== exp.sector_changed) ||
            (got.outputs_off !== exp.outputs_off);
      if (bad) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("compare error at result %0d: exp u=%h v=%h w=%h g=%b chg=%b off=%b",
                   checked, exp.compare_u, exp.compare_v, exp.compare_w, exp.gate_enables,
                   exp.sector_changed, exp.outputs_off);
          $display("  got u=%h v=%h w=%h g=%b chg=%b off=%b",
                   got.compare_u, got.compare_v, got.compare_w, got.gate_enables,
                   got.sector_changed, got.outputs_off);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  hssc_in_if  in_ch ();
  hssc_out_if out_ch ();

  hall_six_step_commutator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  commutation_scoreboard sb;
  bit          sender_idle;
  bit          stall_on;
  int unsigned items_sent;
  int unsigned periods_written;
  int unsigned idle_cycles;
  result_t     observed;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.hall_code, in_ch.duty_request);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      observed.compare_u      = out_ch.compare_u;
      observed.compare_v      = out_ch.compare_v;
      observed.compare_w      = out_ch.compare_w;
      observed.gate_enables   = out_ch.gate_enables;
      observed.sector_changed = out_ch.sector_changed;
      observed.outputs_off    = out_ch.outputs_off;
      sb.check_result(observed);
    end
  end

  always begin
    @(posedge clk);
    if (rst_n && stall_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("hall_six_step_commutator_core: mismatch");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] pick_duty(input logic [WordW-1:0] per);
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 19);
    if (sel < 9)
      return WordW'($urandom);
    if (sel < 13) begin
      v = int'(per) + int'($urandom_range(0, 8)) - 4;
      if (v < 1)
        v = 1;
      if (v > 65535)
        v = 65535;
      return WordW'(v);
    end
    if (sel < 17)
      return WordW'($urandom_range(1, 255));
    if (sel < 19)
      return 16'hFFFF;
    return 16'h0000;
  endfunction

  task automatic send_item(input logic [HallW-1:0] h, input logic [WordW-1:0] d);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.hall_code    <= h;
    in_ch.duty_request <= d;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_period(input logic [WordW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(REG_PWM_PERIOD));
    pwdata  <= DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_period(value);
    periods_written++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int sent;
    int kind;
    int pos;
    int dir;
    int len;
    int k;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        dir = $urandom_range(0, 1) ? 1 : 5;
        pos = $urandom_range(0, 5);
        len = $urandom_range(3, 12);
        for (k = 0; k < len && sent < n; k++) begin
          if ($urandom_range(0, 4) != 0)
            pos = (pos + dir) % 6;
          send_item(HallOrder[pos], pick_duty(sb.period));
          sent++;
        end
      end else if (kind == 7) begin
        send_item(HallW'($urandom_range(0, 7)), WordW'($urandom));
        sent++;
      end else if (kind == 8) begin
        send_item($urandom_range(0, 1) ? HallAll : HallNone, pick_duty(sb.period));
        sent++;
      end else begin
        send_item(HallOrder[$urandom_range(0, 5)], '0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [WordW-1:0] plan [7];
    int               i;
    sb              = new();
    items_sent      = 0;
    periods_written = 0;
    idle_cycles     = 0;
    sender_idle     = 1'b1;
    stall_on        = 1'b1;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.hall_code    <= '0;
    in_ch.duty_request <= '0;
    out_ch.ready       <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(3'd1, 16'hFFFF);
    send_item(3'd1, 16'hFFFF);
    send_item(3'd3, 16'h0001);
    send_item(3'd2, 16'h5555);
    send_item(3'd6, 16'hAAAA);
    send_item(3'd4, 16'h8000);
    send_item(3'd5, 16'h7FFF);
    send_item(HallNone, 16'h1234);
    send_item(HallAll, 16'hFFFF);
    send_item(3'd5, 16'h0000);
    send_item(3'd5, 16'h00FF);
    wait_drained();
    write_period(16'd1000);
    send_item(3'd4, 16'd2000);
    send_item(3'd4, 16'd1000);
    send_item(3'd6, 16'd999);
    send_item(3'd2, 16'hFFFF);
    wait_drained();
    write_period(16'h0000);
    send_item(3'd3, 16'd5);
    send_item(3'd3, 16'hFFFF);
    send_item(3'd1, 16'h0000);
    send_item(3'd6, 16'd1);

    plan[0] = 16'hFFFF;
    plan[1] = 16'h0000;
    plan[2] = 16'h0001;
    plan[3] = WordW'($urandom_range(2, 2000));
    plan[4] = 16'h8000;
    plan[5] = WordW'($urandom_range(1, 65534));
    plan[6] = 16'hFFFF;
    for (i = 0; i < 7; i++) begin
      sender_idle = (i != 3 && i != 6);
      stall_on    = (i != 3 && i != 6);
      wait_drained();
      write_period(plan[i]);
      if (i == 2) begin
        run_random(PhaseItems / 2);
        wait_drained();
        run_random(PhaseItems - PhaseItems / 2);
      end else begin
        run_random(PhaseItems);
      end
    end
    wait_drained();

    $display("ran %0d transactions under %0d periods: %0d off, %0d sector changes, %0d clamped",
             items_sent, periods_written, sb.off_seen, sb.changed_seen, sb.clamped_seen);
    $display("checked %0d results, %0d errors, %0d still outstanding",
             sb.checked, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hall_six_step_commutator_core: match");
    end else begin
      $display("hall_six_step_commutator_core: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hssc_pkg.sv
hdl/hssc_if.sv
hdl/hssc_commutate.sv
hdl/hall_six_step_commutator_core.sv
tb/sv/testbench.sv
